// ----- rtl/core/pbtd_pkg.sv -----
// Package: shared types and constants for the packet buffer tail drop unit.
`timescale 1ns / 1ps
`default_nettype none
package pbtd_pkg;

	localparam int DEPTH   = 64;
	localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int OCC_W   = $clog2(DEPTH + 1);
	localparam int BSIZE_W = 7;
	localparam int CMP_W   = (OCC_W > BSIZE_W) ? OCC_W : BSIZE_W;
	localparam int TIME_W  = 32;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [BSIZE_W-1:0] BSIZE_RESET = BSIZE_W'(64);
	localparam logic REG_BUFFER_SIZE = 1'b0;

	typedef struct packed {
		logic [TIME_W-1:0] arrival;
		logic [TIME_W-1:0] service;
	} pbtd_in_t;

	typedef struct packed {
		logic              dropped;
		logic [TIME_W-1:0] svc_start;
	} pbtd_out_t;

	typedef struct packed {
		logic     valid;
		pbtd_in_t item;
	} pbtd_q_t;

endpackage
`default_nettype wire

// ----- rtl/core/pbtd_front.sv -----
// Front end: accepts packet transactions into a short command queue.
`timescale 1ns / 1ps
`default_nettype none
module pbtd_front
	import pbtd_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	input  wire pbtd_in_t item,
	output logic          busy,
	input  wire logic     pop,
	output pbtd_q_t       head
);

	pbtd_in_t          entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              push;
	logic              do_pop;

	assign busy   = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign push   = start && !busy;
	assign do_pop = pop && (cnt_q != '0);

	assign head.valid = (cnt_q != '0);
	assign head.item  = entry_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wptr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			case ({push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/pbtd_engine.sv -----
// Back end: retires expired finish times, decides drop, schedules packets.
`timescale 1ns / 1ps
`default_nettype none
module pbtd_engine
	import pbtd_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [BSIZE_W-1:0] buffer_size,
	input  wire pbtd_q_t            head,
	output logic                    pop,
	output logic                    done,
	output pbtd_out_t               result
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EVAL = 2'b10
	} state_t;

	state_t            state_q;
	pbtd_in_t          job_q;
	logic [TIME_W-1:0] mem [DEPTH];
	logic [TIME_W-1:0] rd_q;
	logic [TIME_W-1:0] last_q;
	logic [ADDR_W-1:0] head_q;
	logic [ADDR_W-1:0] head_d;
	logic [ADDR_W-1:0] tail_q;
	logic [OCC_W-1:0]  occ_q;
	logic              done_q;
	pbtd_out_t         res_q;

	logic              eval;
	logic              retire;
	logic              full;
	logic              we;
	logic [CMP_W-1:0]  cap;
	logic [TIME_W-1:0] start_t;
	logic [TIME_W:0]   sum;
	logic [TIME_W-1:0] fin;

	assign eval   = (state_q == ST_EVAL);
	assign retire = eval && (occ_q != '0) && (rd_q <= job_q.arrival);
	assign cap    = (CMP_W'(buffer_size) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH)
	                                                     : CMP_W'(buffer_size);
	assign full   = CMP_W'(occ_q) >= cap;
	assign we     = eval && !retire && !full;
	assign start_t = ((occ_q != '0) && (last_q > job_q.arrival)) ? last_q
	                                                              : job_q.arrival;
	assign sum    = {1'b0, start_t} + {1'b0, job_q.service};
	assign fin    = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
	assign head_d = retire ? ((head_q == ADDR_W'(DEPTH - 1)) ? '0 : head_q + 1'b1) : head_q;
	assign pop    = (state_q == ST_IDLE) && head.valid;

	assign done   = done_q;
	assign result = res_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[tail_q] <= fin;
		end
		rd_q <= (we && (tail_q == head_d)) ? fin : mem[head_d];
		if (pop) begin
			job_q <= head.item;
		end
		if (we) begin
			last_q <= fin;
		end
		if (eval && !retire) begin
			res_q.dropped   <= full;
			res_q.svc_start <= full ? '0 : start_t;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			occ_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			head_q <= head_d;
			done_q <= eval && !retire;
			if (retire) begin
				occ_q <= occ_q - 1'b1;
			end else if (we) begin
				occ_q  <= occ_q + 1'b1;
				tail_q <= (tail_q == ADDR_W'(DEPTH - 1)) ? '0 : tail_q + 1'b1;
			end
			case (state_q)
				ST_IDLE: if (pop) state_q <= ST_EVAL;
				ST_EVAL: if (!retire) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_W'(DEPTH))
		else $error("occupancy above depth");

	a_no_write_full: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (occ_q < OCC_W'(DEPTH)))
		else $error("enqueue into full store");

	a_done_after_eval: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($past(state_q) == ST_EVAL))
		else $error("result without evaluation");

	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && res_q.dropped) |-> (res_q.svc_start == '0))
		else $error("dropped packet with nonzero start");

endmodule
`default_nettype wire

// ----- rtl/core/packet_buffer_tail_drop_unit.sv -----
// Top level: packet buffer tail drop unit with APB configuration register.
//
// Usage: a packet transaction (arrival, service) is accepted on
// item at a rising edge where start is high and busy is low. The front end
// queues up to two transactions; busy is high only while that queue is full.
// Each packet yields one result (dropped, svc_start) on result, marked by
// done for exactly one cycle; the receiver cannot stall it.
// Accepted packets pass the front-end queue, the pop into the engine's job
// register, one evaluation step per retired finish time and a final step that
// registers the result. Throughput is limited by the single finish-time memory
// read port walked one head entry per cycle; the queue buffers packets meanwhile.
// buffer_size sits at APB address 0 (reset 64, capped at the store depth);
// write it only while the block is idle.
// Reset clears the queue, the head/tail pointers and occupancy; the
// finish-time store needs no clearing since only occupied entries are read.
`timescale 1ns / 1ps
`default_nettype none
module packet_buffer_tail_drop_unit
	import pbtd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire pbtd_in_t    item,
	output logic             done,
	output pbtd_out_t        result,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic [BSIZE_W-1:0] bsize_q;
	pbtd_q_t            qhead;
	logic               pop;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_BUFFER_SIZE) ? {{(32 - BSIZE_W){1'b0}}, bsize_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bsize_q <= BSIZE_RESET;
		end else if (psel && penable && pwrite && (paddr[2] == REG_BUFFER_SIZE)) begin
			bsize_q <= pwdata[BSIZE_W-1:0];
		end
	end

	pbtd_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.busy   (busy),
		.pop    (pop),
		.head   (qhead)
	);

	pbtd_engine u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.buffer_size (bsize_q),
		.head        (qhead),
		.pop         (pop),
		.done        (done),
		.result      (result)
	);

endmodule
`default_nettype wire

// ----- tb/packet_buffer_tail_drop_checker.sv -----
// Checker: predicts packet outcomes from observed transactions and compares them with the results.
`timescale 1ns / 1ps
module packet_buffer_tail_drop_checker
	import pbtd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic        busy,
	input  wire pbtd_in_t    item,
	input  wire logic        done,
	input  wire pbtd_out_t   result,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	input  wire logic        pready,
	output int               mismatches,
	output int               pending
);

	localparam logic [2:0] BUFFER_SIZE_ADDR = {REG_BUFFER_SIZE, 2'b00};

	logic [BSIZE_W-1:0] buffer_size;
	logic [TIME_W-1:0]  finish_q[$];
	pbtd_out_t          outcome_q[$];

	// Retire expired finish times, then drop or schedule the packet.
	function automatic pbtd_out_t admit_packet(input pbtd_in_t pkt);
		pbtd_out_t      outcome;
		logic [TIME_W:0] sum;
		int             capacity;
		capacity = (buffer_size > DEPTH) ? DEPTH : int'(buffer_size);
		while (finish_q.size() > 0 && finish_q[0] <= pkt.arrival)
			void'(finish_q.pop_front());
		outcome = '0;
		if (finish_q.size() >= capacity) begin
			outcome.dropped = 1'b1;
		end else begin
			outcome.svc_start = pkt.arrival;
			if (finish_q.size() > 0 && finish_q[$] > outcome.svc_start)
				outcome.svc_start = finish_q[$];
			sum = {1'b0, outcome.svc_start} + {1'b0, pkt.service};
			finish_q.insert(finish_q.size(), sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0]);
		end
		return outcome;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pbtd_out_t want;
		if (!arst_n) begin
			buffer_size = BSIZE_RESET;
			finish_q.delete();
			outcome_q.delete();
			mismatches = 0;
			pending = 0;
		end else begin
			if (done) begin
				if (outcome_q.size() == 0) begin
					$display("%0t: result with none expected, actual dropped=%0b svc_start=%0h",
						$time, result.dropped, result.svc_start);
					mismatches++;
				end else begin
					want = outcome_q.pop_front();
					if (result.dropped !== want.dropped) begin
						$display("%0t: dropped expected %0b actual %0b",
							$time, want.dropped, result.dropped);
						mismatches++;
					end
					if (result.svc_start !== want.svc_start) begin
						$display("%0t: svc_start expected %0h actual %0h",
							$time, want.svc_start, result.svc_start);
						mismatches++;
					end
				end
			end
			if (start && !busy)
				outcome_q.insert(outcome_q.size(), admit_packet(item));
			if (psel && penable && pwrite && pready && paddr == BUFFER_SIZE_ADDR)
				buffer_size = pwdata[BSIZE_W-1:0];
			pending = outcome_q.size();
		end
	end

endmodule

// ----- tb/testbench.sv -----
// Testbench top: drives packet transactions and APB writes, reports the verdict.
`timescale 1ns / 1ps
module testbench;
	import pbtd_pkg::*;

	localparam logic [2:0]        BUFFER_SIZE_ADDR = {REG_BUFFER_SIZE, 2'b00};
	localparam int                WATCHDOG_LIMIT   = 5000;
	localparam int                SEGMENT_ITEMS    = 250;
	localparam logic [TIME_W-1:0] TIME_MAX         = '1;

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              start    = 1'b0;
	pbtd_in_t          item     = '0;
	logic              psel     = 1'b0;
	logic              penable  = 1'b0;
	logic              pwrite   = 1'b0;
	logic [2:0]        paddr    = '0;
	logic [31:0]       pwdata   = '0;
	logic              busy;
	logic              done;
	pbtd_out_t         result;
	logic [31:0]       prdata;
	logic              pready;
	int                mismatches;
	int                pending;
	int                stall_cycles = 0;
	logic [TIME_W-1:0] now_time     = '0;

	always #5 clk = ~clk;

	packet_buffer_tail_drop_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	packet_buffer_tail_drop_checker outcome_check (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .pready(pready),
		.mismatches(mismatches), .pending(pending)
	);

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	task automatic wait_idle();
		@(negedge clk) start <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic send_packet(input logic [TIME_W-1:0] arrival, input logic [TIME_W-1:0] proc,
		input int idle_pct);
		@(negedge clk);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		item <= '{arrival: arrival, service: proc};
		while (busy) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic write_buffer_size(input logic [BSIZE_W-1:0] value);
		wait_idle();
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= BUFFER_SIZE_ADDR;
		pwdata <= 32'(value);
		@(negedge clk) penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// flush: size 0 plus an arrival at the time limit empties the buffer
	task automatic run_segment(input logic [BSIZE_W-1:0] size, input int idle_pct,
		input int delta_max, input int proc_max, input bit flush,
		input logic [TIME_W-1:0] base, input bit tail_noise);
		logic [TIME_W:0]   sum;
		logic [TIME_W-1:0] arr;
		logic [TIME_W-1:0] proc;
		int                roll;
		int                gap;
		int                dec;
		if (flush) begin
			write_buffer_size('0);
			send_packet(TIME_MAX, '0, 0);
			now_time = base;
		end
		write_buffer_size(size);
		for (int k = 0; k < SEGMENT_ITEMS; k++) begin
			roll = $urandom_range(0, 99);
			gap = ((k / 40) % 3 == 2) ? 0 : idle_pct;
			proc = $urandom_range(0, proc_max);
			if (roll < 4) begin
				dec = $urandom_range(0, 50);
				arr = (now_time > TIME_W'(dec)) ? now_time - TIME_W'(dec) : '0;
			end else begin
				if (tail_noise && k >= SEGMENT_ITEMS - 4)
					sum = {1'b0, now_time} + $urandom_range(0, 3000);
				else if (roll < 8)
					sum = {1'b0, now_time} + $urandom_range(0, 2000);
				else
					sum = {1'b0, now_time} + $urandom_range(0, delta_max);
				now_time = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
				arr = now_time;
			end
			if (tail_noise && k >= SEGMENT_ITEMS - 4)
				proc = $urandom();
			if ($urandom_range(0, 149) == 0)
				wait_idle();
			send_packet(arr, proc, gap);
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		send_packet(0, 0, 0);
		send_packet(0, 5, 0);
		send_packet(2, 3, 0);
		send_packet(10, TIME_MAX, 0);
		send_packet(20, 1, 0);
		send_packet(15, 0, 0);
		send_packet(TIME_MAX, TIME_MAX, 0);

		write_buffer_size(BSIZE_W'(0));
		send_packet(TIME_MAX, 0, 0);
		send_packet(0, 7, 0);

		write_buffer_size(BSIZE_W'(1));
		send_packet(0, 10, 0);
		send_packet(3, 1, 0);
		send_packet(10, 1, 0);
		send_packet(5, 2, 0);

		write_buffer_size(BSIZE_W'(2));
		send_packet(12, 0, 0);
		send_packet(12, 4, 0);
		send_packet(13, 4, 0);
		send_packet(14, 1, 0);

		run_segment(BSIZE_W'(1), 38, 10, 15, 1'b1, $urandom_range(0, 32'hF000_0000), 1'b1);
		run_segment(BSIZE_W'(64), 38, 6, 15, 1'b1, $urandom_range(0, 32'hF000_0000), 1'b1);
		run_segment(BSIZE_W'(127), 70, 6, 16, 1'b1, $urandom_range(0, 32'hF000_0000), 1'b0);
		// size drops below the current occupancy
		run_segment(BSIZE_W'(5), 70, 10, 12, 1'b0, '0, 1'b1);
		run_segment(BSIZE_W'(16), 0, 10, 20, 1'b1, 32'hFFFF_F800, 1'b1);
		run_segment(BSIZE_W'(2), 0, 8, 20, 1'b1, $urandom_range(0, 32'hF000_0000), 1'b1);

		wait_idle();
		repeat (10) @(negedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
